FILE: sv/ssoh_pkg.sv
// Shared constants for the swept sphere versus oriented box hit test.
package ssoh_pkg;

	// Sphere radius register, unsigned Q11.8
	localparam int RADIUS_W = 19;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 19'd256;

	// Number of box axes
	localparam int NUM_AXES = 3;

	// Queue between the transform front and the slab back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

endpackage

FILE: sv/ssoh_ifs.sv
// Valid/ready channel interfaces for query items and result items.
interface ssoh_query_if #(
	parameter int COORD_WIDTH = 20,
	parameter int QUAT_WIDTH = 16
);
	logic valid;
	logic ready;
	logic [3*COORD_WIDTH-1:0] segment_start;
	logic [3*COORD_WIDTH-1:0] segment_end;
	logic [3*COORD_WIDTH-1:0] box_center;
	logic [3*COORD_WIDTH-1:0] box_half_size;
	logic [4*QUAT_WIDTH-1:0] box_rotation;

	modport source (output valid, segment_start, segment_end, box_center, box_half_size,
		box_rotation, input ready);
	modport sink (input valid, segment_start, segment_end, box_center, box_half_size,
		box_rotation, output ready);
endinterface

interface ssoh_result_if #(
	parameter int TIME_FRAC_BITS = 16
);
	logic valid;
	logic ready;
	logic hit;
	logic [TIME_FRAC_BITS:0] hit_time;

	modport source (output valid, hit, hit_time, input ready);
	modport sink (input valid, hit, hit_time, output ready);
endinterface

FILE: sv/swept_sphere_obb_hit_test.sv
// Swept sphere against oriented box hit test, top level.
// Takes one segment/box query per clock and returns one hit item per query, in order.
// Sustained rate is one item per cycle unless result.ready stalls it: the quaternion
// transform (4 stages), the slab clip (5 stages per axis, 15 total) and the divider
// (TIME_FRAC_BITS+1 stages, one quotient bit each) are all fully pipelined, with a
// 4-entry queue between transform and slab test. The user must write the sphere radius
// register via radius_we/radius_wdata only while idle; the block does not enforce it.
module swept_sphere_obb_hit_test import ssoh_pkg::*; #(
	parameter int COORD_WIDTH = 20,
	parameter int QUAT_WIDTH = 16,
	parameter int TIME_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic radius_we,
	input  logic [RADIUS_W-1:0] radius_wdata,
	ssoh_query_if.sink query,
	ssoh_result_if.source result
);
	localparam int LW = COORD_WIDTH + 10;
	localparam int HW = ((COORD_WIDTH > RADIUS_W) ? COORD_WIDTH : RADIUS_W) + 1;
	localparam int EW = ((LW > HW) ? LW : HW) + 2;
	localparam int QW_ITEM = NUM_AXES * (2 * LW + HW);

	logic f_valid, f_ready;
	logic [NUM_AXES-1:0][LW-1:0] f_ls, f_le, b_ls, b_le;
	logic [NUM_AXES-1:0][HW-1:0] f_hb, b_hb;
	logic [QW_ITEM-1:0] q_push, q_pop;
	logic b_valid, b_ready;
	logic w_valid, w_ready, w_hit;
	logic signed [EW-1:0] w_tn, w_td;

	// transform front
	ssoh_front #(.CW(COORD_WIDTH), .QW(QUAT_WIDTH), .LW(LW), .HW(HW)) u_front (
		.clk, .arst_n, .radius_we, .radius_wdata, .query,
		.local_valid(f_valid), .local_ready(f_ready),
		.ls(f_ls), .le(f_le), .hb(f_hb)
	);

	assign q_push = {f_ls, f_le, f_hb};
	assign {b_ls, b_le, b_hb} = q_pop;

	// decoupling queue
	ssoh_queue #(.W(QW_ITEM)) u_queue (
		.clk, .arst_n,
		.push_valid(f_valid), .push_ready(f_ready), .push_data(q_push),
		.pop_valid(b_valid), .pop_ready(b_ready), .pop_data(q_pop)
	);

	// slab test back
	ssoh_back #(.LW(LW), .HW(HW), .EW(EW)) u_back (
		.clk, .arst_n,
		.item_valid(b_valid), .item_ready(b_ready),
		.ls(b_ls), .le(b_le), .hb(b_hb),
		.win_valid(w_valid), .win_ready(w_ready),
		.tmin_n(w_tn), .tmin_d(w_td), .hit(w_hit)
	);

	// entry time division and result register
	ssoh_div #(.EW(EW), .TFB(TIME_FRAC_BITS)) u_div (
		.clk, .arst_n,
		.win_valid(w_valid), .win_ready(w_ready),
		.tmin_n(w_tn), .tmin_d(w_td), .hit(w_hit),
		.result
	);

endmodule

FILE: sv/ssoh_front.sv
// Front part: accepts query items, moves both points into the box frame, grows the box.
module ssoh_front import ssoh_pkg::*; #(
	parameter int CW = 20,
	parameter int QW = 16,
	parameter int LW = 30,
	parameter int HW = 21
) (
	input  logic clk,
	input  logic arst_n,
	input  logic radius_we,
	input  logic [RADIUS_W-1:0] radius_wdata,
	ssoh_query_if.sink query,
	output logic local_valid,
	input  logic local_ready,
	output logic [NUM_AXES-1:0][LW-1:0] ls,
	output logic [NUM_AXES-1:0][LW-1:0] le,
	output logic [NUM_AXES-1:0][HW-1:0] hb
);
	localparam int DW = CW + 1;
	localparam int PQ = 2 * QW;
	localparam int MW = 2 * QW + 2;
	localparam int PW = MW + DW;
	localparam int SW = PW + 2;
	localparam int RS = 2 * (QW - 2);
	localparam logic signed [SW-1:0] HALF = SW'(1) <<< (RS - 1);

	logic [RADIUS_W-1:0] radius_q;
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;

	// stage 1: offsets from center, grown extents, quaternion products
	logic signed [DW-1:0] ds_d [NUM_AXES];
	logic signed [DW-1:0] de_d [NUM_AXES];
	logic [NUM_AXES-1:0][HW-1:0] hb_d;
	logic signed [QW-1:0] qx, qy, qz, qw;
	logic signed [DW-1:0] ds_s1 [NUM_AXES];
	logic signed [DW-1:0] de_s1 [NUM_AXES];
	logic [NUM_AXES-1:0][HW-1:0] hb_s1;
	logic signed [PQ-1:0] pxx_s1, pyy_s1, pzz_s1, pww_s1;
	logic signed [PQ-1:0] pxy_s1, pzw_s1, pxz_s1, pyw_s1, pyz_s1, pxw_s1;

	// stage 2: rotation matrix
	logic signed [MW-1:0] m_d [3][3];
	logic signed [MW-1:0] m_s2 [3][3];
	logic signed [DW-1:0] ds_s2 [NUM_AXES];
	logic signed [DW-1:0] de_s2 [NUM_AXES];
	logic [NUM_AXES-1:0][HW-1:0] hb_s2;

	// stage 3: matrix times offset products
	logic signed [PW-1:0] ps_s3 [3][3];
	logic signed [PW-1:0] pe_s3 [3][3];
	logic [NUM_AXES-1:0][HW-1:0] hb_s3;

	// stage 4: sums and rounding
	logic [NUM_AXES-1:0][LW-1:0] ls_d, le_d;
	logic [NUM_AXES-1:0][LW-1:0] ls_s4, le_s4;
	logic [NUM_AXES-1:0][HW-1:0] hb_s4;

	function automatic logic signed [LW-1:0] round_q(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] a;
		if (v >= 0) begin
			a = (v + HALF) >>> RS;
		end else begin
			a = -((-v + HALF) >>> RS);
		end
		return LW'(a);
	endfunction

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (radius_we) begin
			radius_q <= radius_wdata;
		end
	end

	// whole front advances when its last stage is empty or drained
	assign adv = !v_s4 || local_ready;
	assign query.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= query.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// unpack and difference
	always_comb begin
		logic signed [CW-1:0] st, en, ct;
		for (int k = 0; k < NUM_AXES; k++) begin
			st = signed'(query.segment_start[k*CW +: CW]);
			en = signed'(query.segment_end[k*CW +: CW]);
			ct = signed'(query.box_center[k*CW +: CW]);
			ds_d[k] = {st[CW-1], st} - {ct[CW-1], ct};
			de_d[k] = {en[CW-1], en} - {ct[CW-1], ct};
			hb_d[k] = HW'(query.box_half_size[k*CW +: CW]) + HW'(radius_q);
		end
		qx = signed'(query.box_rotation[0 +: QW]);
		qy = signed'(query.box_rotation[QW +: QW]);
		qz = signed'(query.box_rotation[2*QW +: QW]);
		qw = signed'(query.box_rotation[3*QW +: QW]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ds_s1 <= ds_d;
			de_s1 <= de_d;
			hb_s1 <= hb_d;
			pxx_s1 <= qx * qx;
			pyy_s1 <= qy * qy;
			pzz_s1 <= qz * qz;
			pww_s1 <= qw * qw;
			pxy_s1 <= qx * qy;
			pzw_s1 <= qz * qw;
			pxz_s1 <= qx * qz;
			pyw_s1 <= qy * qw;
			pyz_s1 <= qy * qz;
			pxw_s1 <= qx * qw;
		end
	end

	// homogeneous rotation matrix
	always_comb begin
		m_d[0][0] = MW'(pww_s1) + MW'(pxx_s1) - MW'(pyy_s1) - MW'(pzz_s1);
		m_d[1][1] = MW'(pww_s1) - MW'(pxx_s1) + MW'(pyy_s1) - MW'(pzz_s1);
		m_d[2][2] = MW'(pww_s1) - MW'(pxx_s1) - MW'(pyy_s1) + MW'(pzz_s1);
		m_d[0][1] = (MW'(pxy_s1) - MW'(pzw_s1)) <<< 1;
		m_d[0][2] = (MW'(pxz_s1) + MW'(pyw_s1)) <<< 1;
		m_d[1][0] = (MW'(pxy_s1) + MW'(pzw_s1)) <<< 1;
		m_d[1][2] = (MW'(pyz_s1) - MW'(pxw_s1)) <<< 1;
		m_d[2][0] = (MW'(pxz_s1) - MW'(pyw_s1)) <<< 1;
		m_d[2][1] = (MW'(pyz_s1) + MW'(pxw_s1)) <<< 1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s2 <= m_d;
			ds_s2 <= ds_s1;
			de_s2 <= de_s1;
			hb_s2 <= hb_s1;
		end
	end

	// transpose times offset, one product per register
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					ps_s3[k][j] <= m_s2[j][k] * ds_s2[j];
					pe_s3[k][j] <= m_s2[j][k] * de_s2[j];
				end
			end
			hb_s3 <= hb_s2;
		end
	end

	// sum of three and round to Q.8
	always_comb begin
		logic signed [SW-1:0] sa, se;
		for (int k = 0; k < 3; k++) begin
			sa = SW'(ps_s3[k][0]) + SW'(ps_s3[k][1]) + SW'(ps_s3[k][2]);
			se = SW'(pe_s3[k][0]) + SW'(pe_s3[k][1]) + SW'(pe_s3[k][2]);
			ls_d[k] = round_q(sa);
			le_d[k] = round_q(se);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ls_s4 <= ls_d;
			le_s4 <= le_d;
			hb_s4 <= hb_s3;
		end
	end

	assign local_valid = v_s4;
	assign ls = ls_s4;
	assign le = le_s4;
	assign hb = hb_s4;

endmodule

FILE: sv/ssoh_queue.sv
// Short item queue between the transform front and the slab back.
module ssoh_queue import ssoh_pkg::*; #(
	parameter int W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  logic [W-1:0] push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output logic [W-1:0] pop_data
);
	logic [W-1:0] mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic push, pop;

	assign push_ready = cnt_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data = mem_q[rp_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");
	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a push");

endmodule

FILE: sv/ssoh_back.sv
// Back part: slab test on x, y and z, clipping the entry/exit window one axis at a time.
module ssoh_back import ssoh_pkg::*; #(
	parameter int LW = 30,
	parameter int HW = 21,
	parameter int EW = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  logic [NUM_AXES-1:0][LW-1:0] ls,
	input  logic [NUM_AXES-1:0][LW-1:0] le,
	input  logic [NUM_AXES-1:0][HW-1:0] hb,
	output logic win_valid,
	input  logic win_ready,
	output logic signed [EW-1:0] tmin_n,
	output logic signed [EW-1:0] tmin_d,
	output logic hit
);
	localparam int XW = 2 * EW;

	typedef struct packed {
		logic [NUM_AXES-1:0][LW-1:0] ls;
		logic [NUM_AXES-1:0][LW-1:0] le;
		logic [NUM_AXES-1:0][HW-1:0] hb;
		logic signed [EW-1:0] tn;
		logic signed [EW-1:0] td;
		logic signed [EW-1:0] xn;
		logic signed [EW-1:0] xd;
		logic hit;
	} ctx_t;

	ctx_t in_ctx;
	ctx_t c_s1 [NUM_AXES], c_s2 [NUM_AXES], c_s3 [NUM_AXES], c_s4 [NUM_AXES];
	ctx_t c_s5 [NUM_AXES];
	ctx_t c1_d [NUM_AXES], c3_d [NUM_AXES], c5_d [NUM_AXES];
	logic [NUM_AXES-1:0] v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [NUM_AXES-1:0] zero_s1, zero_s2, zero_s3, zero_s4, inside_s1, inside_s2;
	logic [NUM_AXES-1:0] zero_d, inside_d;
	logic signed [EW-1:0] en_d [NUM_AXES], ex_d [NUM_AXES], den_d [NUM_AXES];
	logic signed [EW-1:0] en_s1 [NUM_AXES], ex_s1 [NUM_AXES], den_s1 [NUM_AXES];
	logic signed [EW-1:0] en_s2 [NUM_AXES], ex_s2 [NUM_AXES], den_s2 [NUM_AXES];
	logic signed [XW-1:0] pen_s2 [NUM_AXES], ptn_s2 [NUM_AXES];
	logic signed [XW-1:0] pex_s2 [NUM_AXES], pxn_s2 [NUM_AXES];
	logic signed [XW-1:0] w1_s4 [NUM_AXES], w2_s4 [NUM_AXES];
	logic adv;

	assign adv = !v_s5[NUM_AXES-1] || win_ready;
	assign item_ready = adv;

	// window starts at [0, 1]
	always_comb begin
		in_ctx.ls = ls;
		in_ctx.le = le;
		in_ctx.hb = hb;
		in_ctx.tn = '0;
		in_ctx.td = EW'(1);
		in_ctx.xn = EW'(1);
		in_ctx.xd = EW'(1);
		in_ctx.hit = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= '0;
			v_s2 <= '0;
			v_s3 <= '0;
			v_s4 <= '0;
			v_s5 <= '0;
		end else if (adv) begin
			v_s1 <= {v_s5[NUM_AXES-2:0], item_valid};
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// step 1: direction, slab distances, containment for a still axis
	always_comb begin
		ctx_t cin;
		logic signed [EW-1:0] p0, dir, mx, mn;
		for (int k = 0; k < NUM_AXES; k++) begin
			cin = (k == 0) ? in_ctx : c_s5[(k == 0) ? 0 : k-1];
			p0 = EW'(signed'(cin.ls[k]));
			dir = EW'(signed'(cin.le[k])) - p0;
			mx = EW'({1'b0, cin.hb[k]});
			mn = -mx;
			zero_d[k] = dir == '0;
			inside_d[k] = !(p0 < mn || p0 > mx);
			if (dir > 0) begin
				en_d[k] = mn - p0;
				ex_d[k] = mx - p0;
				den_d[k] = dir;
			end else begin
				en_d[k] = p0 - mx;
				ex_d[k] = p0 - mn;
				den_d[k] = -dir;
			end
			c1_d[k] = cin;
		end
	end

	// step 3: clip the window by the new fractions
	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			c3_d[k] = c_s2[k];
			if (zero_s2[k]) begin
				c3_d[k].hit = c_s2[k].hit && inside_s2[k];
			end else begin
				if (pen_s2[k] > ptn_s2[k]) begin
					c3_d[k].tn = en_s2[k];
					c3_d[k].td = den_s2[k];
				end
				if (pex_s2[k] < pxn_s2[k]) begin
					c3_d[k].xn = ex_s2[k];
					c3_d[k].xd = den_s2[k];
				end
			end
		end
	end

	// step 5: empty window ends the test
	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			c5_d[k] = c_s4[k];
			if (!zero_s4[k] && w1_s4[k] > w2_s4[k]) begin
				c5_d[k].hit = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				c_s1[k] <= c1_d[k];
				zero_s1[k] <= zero_d[k];
				inside_s1[k] <= inside_d[k];
				en_s1[k] <= en_d[k];
				ex_s1[k] <= ex_d[k];
				den_s1[k] <= den_d[k];
				// step 2: cross products against the current window
				c_s2[k] <= c_s1[k];
				zero_s2[k] <= zero_s1[k];
				inside_s2[k] <= inside_s1[k];
				en_s2[k] <= en_s1[k];
				ex_s2[k] <= ex_s1[k];
				den_s2[k] <= den_s1[k];
				pen_s2[k] <= en_s1[k] * c_s1[k].td;
				ptn_s2[k] <= c_s1[k].tn * den_s1[k];
				pex_s2[k] <= ex_s1[k] * c_s1[k].xd;
				pxn_s2[k] <= c_s1[k].xn * den_s1[k];
				c_s3[k] <= c3_d[k];
				zero_s3[k] <= zero_s2[k];
				// step 4: window order check products
				c_s4[k] <= c_s3[k];
				zero_s4[k] <= zero_s3[k];
				w1_s4[k] <= c_s3[k].tn * c_s3[k].xd;
				w2_s4[k] <= c_s3[k].xn * c_s3[k].td;
				c_s5[k] <= c5_d[k];
			end
		end
	end

	assign win_valid = v_s5[NUM_AXES-1];
	assign tmin_n = c_s5[NUM_AXES-1].tn;
	assign tmin_d = c_s5[NUM_AXES-1].td;
	assign hit = c_s5[NUM_AXES-1].hit;

endmodule

FILE: sv/ssoh_div.sv
// Entry time divider: one quotient bit per pipeline stage; the last stage register drives the result.
module ssoh_div #(
	parameter int EW = 32,
	parameter int TFB = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic win_valid,
	output logic win_ready,
	input  logic signed [EW-1:0] tmin_n,
	input  logic signed [EW-1:0] tmin_d,
	input  logic hit,
	ssoh_result_if.source result
);
	localparam int NS = TFB + 1;

	logic [NS-1:0] v_s;
	logic [EW:0] r_s [NS];
	logic [EW:0] r_d [NS];
	logic [EW-1:0] d_s [NS];
	logic [EW-1:0] d_d [NS];
	logic [TFB:0] q_s [NS];
	logic [TFB:0] q_d [NS];
	logic h_s [NS];
	logic h_d [NS];
	logic adv;

	assign adv = !v_s[NS-1] || result.ready;
	assign win_ready = adv;

	// restoring division, quotient MSB first; last stage zeroes a miss
	always_comb begin
		logic [EW:0] r;
		for (int i = 0; i < NS; i++) begin
			if (i == 0) begin
				r = {1'b0, tmin_n};
				d_d[i] = tmin_d;
				q_d[i] = '0;
				h_d[i] = hit;
			end else begin
				r = r_s[(i == 0) ? 0 : i-1] << 1;
				d_d[i] = d_s[(i == 0) ? 0 : i-1];
				q_d[i] = q_s[(i == 0) ? 0 : i-1];
				h_d[i] = h_s[(i == 0) ? 0 : i-1];
			end
			if (r >= {1'b0, d_d[i]}) begin
				r = r - {1'b0, d_d[i]};
				q_d[i][TFB-i] = 1'b1;
			end
			r_d[i] = r;
			if (i == NS-1 && !h_d[i]) begin
				q_d[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[NS-2:0], win_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s <= r_d;
			d_s <= d_d;
			q_s <= q_d;
			h_s <= h_d;
		end
	end

	assign result.valid = v_s[NS-1];
	assign result.hit = h_s[NS-1];
	assign result.hit_time = q_s[NS-1];

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.hit |-> result.hit_time == '0)
		else $error("miss item with nonzero time");
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.hit |-> result.hit_time <= ((TFB+1)'(1) << TFB))
		else $error("entry time above one");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		win_valid && win_ready |=> v_s[0])
		else $error("divider dropped an item");

endmodule
